// ===== sv/rls_pkg.sv =====
// shared types and constants for the rgb565 luma stretch block
// no dependencies; imported by the controller, the datapath and the top level
`default_nettype none

package rls_pkg;

	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 1;
	localparam int unsigned PIX_W      = 16;
	localparam int unsigned LUMA_W     = 8;
	localparam int unsigned X_W        = 15;
	localparam int unsigned SUM_W      = 28;
	localparam int unsigned CNT_W      = 21;
	localparam int unsigned DIV_W      = 21;
	localparam int unsigned QBITS      = 8;

	localparam logic [CNT_W-1:0] MAX_PIXELS = 21'd1048576;
	localparam logic [SUM_W-1:0] SUM_LIMIT  = 28'hFFFFFFF;

	// floor(x / 100) as (x * 41944) >> 22, exact for x below 2^15
	localparam logic [15:0] RECIP_100   = 16'd41944;
	localparam int unsigned RECIP_SHIFT = 22;

	localparam logic [LUMA_W-1:0] LUMA_FULL      = 8'd255;
	localparam logic [LUMA_W-1:0] STRETCH_MIN_RG = 8'd8;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_COLLECT_STATS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STRETCH_ENABLE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INVERT_ENABLE  = 2'd2;

	typedef logic [LUMA_W-1:0] luma_t;

	typedef struct packed {
		logic load;
		logic conv;
		logic scale;
		logic acc;
		logic prep;
		logic div_step;
		logic finish;
	} rls_cmd_t;

	typedef struct packed {
		logic need_div;
		logic out_free;
	} rls_stat_t;

endpackage

`default_nettype wire

// ===== sv/rls_ctrl.sv =====
// sequencing controller for the rgb565 luma stretch block
// depends on rls_pkg for command and status types
`default_nettype none

module rls_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_ready,
	input  rls_pkg::rls_stat_t stat,
	output rls_pkg::rls_cmd_t  cmd
);
	import rls_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SCALE,
		ST_ACC,
		ST_PREP,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t          state_q;
	logic [2:0]      div_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			div_cnt_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_CONV;
				end
				ST_CONV:  state_q <= ST_SCALE;
				ST_SCALE: state_q <= ST_ACC;
				ST_ACC:   state_q <= ST_PREP;
				ST_PREP: begin
					div_cnt_q <= '0;
					state_q   <= stat.need_div ? ST_DIV : ST_DONE;
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q + 3'd1;
					if (div_cnt_q == 3'(QBITS - 1)) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (stat.out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd          = '0;
		cmd.load     = (state_q == ST_IDLE) && in_valid;
		cmd.conv     = (state_q == ST_CONV);
		cmd.scale    = (state_q == ST_SCALE);
		cmd.acc      = (state_q == ST_ACC);
		cmd.prep     = (state_q == ST_PREP);
		cmd.div_step = (state_q == ST_DIV);
		cmd.finish   = (state_q == ST_DONE) && stat.out_free;
	end

endmodule

`default_nettype wire

// ===== sv/rls_datapath.sv =====
// datapath of the rgb565 luma stretch block: luma, statistics, shared divider, output register
// depends on rls_pkg; driven by rls_ctrl through the command struct
`default_nettype none

module rls_datapath (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               cfg_we,
	input  wire  [rls_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  wire  [rls_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wire  [rls_pkg::PIX_W-1:0]         pixel,
	input  wire                               frame_end,
	input  rls_pkg::rls_cmd_t                 cmd,
	output rls_pkg::rls_stat_t                stat,
	output logic                              out_valid,
	input  wire                               out_ready,
	output logic [rls_pkg::LUMA_W-1:0]        luma,
	output logic [rls_pkg::LUMA_W-1:0]        stat_min,
	output logic [rls_pkg::LUMA_W-1:0]        stat_max,
	output logic [rls_pkg::LUMA_W-1:0]        stat_avg,
	output logic                              last
);
	import rls_pkg::*;

	// configuration
	logic collect_q, stretch_q, invert_q;
	// item snapshot
	logic [PIX_W-1:0] pix_q;
	logic             fe_q, cs_q, se_q, ie_q;
	// pipeline values
	logic [X_W-1:0]   x_q;
	luma_t            y_q, s_q;
	logic             do_stretch_q;
	// statistics
	luma_t            smin_q, smax_q, savg_q, run_min_q, run_max_q;
	logic [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] cnt_q;
	// divider
	logic [DIV_W-1:0] rem_q, dvs_q;
	luma_t            low_q, quo_q;
	logic             out_valid_q;

	luma_t            r8, g8, b8;
	logic [X_W-1:0]   x_d;
	logic [30:0]      prod;
	luma_t            rng, s_d, y_fin;
	logic             do_stretch_d;
	logic [SUM_W:0]   sum_ext;
	logic [15:0]      p16;
	logic [SUM_W:0]   cnt_sh;
	logic [DIV_W:0]   trial;
	logic             need_div_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			collect_q <= 1'b0;
			stretch_q <= 1'b0;
			invert_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_COLLECT_STATS:  collect_q <= cfg_data[0];
				CFG_STRETCH_ENABLE: stretch_q <= cfg_data[0];
				CFG_INVERT_ENABLE:  invert_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign r8  = {pix_q[15:11], 3'b000};
	assign g8  = {pix_q[10:5], 2'b00};
	assign b8  = {pix_q[4:0], 3'b000};
	assign x_d = X_W'(r8) * X_W'(30) + X_W'(g8) * X_W'(59) + X_W'(b8) * X_W'(11);
	assign prod = 31'(x_q) * 31'(RECIP_100);

	assign rng          = smax_q - smin_q;
	assign do_stretch_d = se_q && !cs_q && (smax_q > smin_q) && (rng > STRETCH_MIN_RG);

	always_comb begin
		s_d = (y_q > smin_q) ? (y_q - smin_q) : '0;
		if (s_d > rng) s_d = rng;
	end

	assign sum_ext = {1'b0, sum_q} + (SUM_W + 1)'(y_q);
	assign p16     = {s_q, 8'b0} - 16'(s_q);
	assign cnt_sh  = {cnt_q, 8'b0};
	assign trial   = {rem_q, low_q[QBITS-1]};

	// divider needed: stretched pixel, or an unsaturated average at a statistics frame end
	assign need_div_d = do_stretch_q
		|| (cs_q && fe_q && (cnt_q != '0) && ({1'b0, sum_q} < cnt_sh));

	always_comb begin
		y_fin = do_stretch_q ? quo_q : y_q;
		if (ie_q) y_fin = LUMA_FULL - y_fin;
	end

	// item pipeline and divider payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pix_q <= pixel;
			fe_q  <= frame_end;
			cs_q  <= collect_q;
			se_q  <= stretch_q;
			ie_q  <= invert_q;
		end
		if (cmd.conv)  x_q <= x_d;
		if (cmd.scale) y_q <= prod[RECIP_SHIFT + LUMA_W - 1:RECIP_SHIFT];
		if (cmd.acc) begin
			s_q          <= s_d;
			do_stretch_q <= do_stretch_d;
		end
		if (cmd.prep) begin
			quo_q <= '0;
			if (do_stretch_q) begin
				rem_q <= DIV_W'(p16[15:8]);
				low_q <= p16[7:0];
				dvs_q <= DIV_W'(rng);
			end else if (cs_q && fe_q) begin
				if (cnt_q == '0) begin
					quo_q <= '0;
				end else if ({1'b0, sum_q} >= cnt_sh) begin
					quo_q <= LUMA_FULL;
				end else begin
					rem_q <= DIV_W'(sum_q[SUM_W-1:8]);
					low_q <= sum_q[7:0];
					dvs_q <= cnt_q;
				end
			end
		end
		if (cmd.div_step) begin
			// restoring step: one quotient bit per cycle
			low_q <= {low_q[QBITS-2:0], 1'b0};
			if (trial >= {1'b0, dvs_q}) begin
				rem_q <= DIV_W'(trial - {1'b0, dvs_q});
				quo_q <= {quo_q[QBITS-2:0], 1'b1};
			end else begin
				rem_q <= trial[DIV_W-1:0];
				quo_q <= {quo_q[QBITS-2:0], 1'b0};
			end
		end
		if (cmd.finish) begin
			luma     <= y_fin;
			last     <= fe_q;
			stat_min <= (fe_q && cs_q) ? run_min_q : smin_q;
			stat_max <= (fe_q && cs_q) ? run_max_q : smax_q;
			stat_avg <= (fe_q && cs_q) ? quo_q : savg_q;
		end
	end

	// statistics state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smin_q    <= '0;
			smax_q    <= '0;
			savg_q    <= '0;
			run_min_q <= LUMA_FULL;
			run_max_q <= '0;
			sum_q     <= '0;
			cnt_q     <= '0;
		end else begin
			if (cmd.acc && cs_q) begin
				if (y_q < run_min_q) run_min_q <= y_q;
				if (y_q > run_max_q) run_max_q <= y_q;
				if (cnt_q < MAX_PIXELS) begin
					cnt_q <= cnt_q + CNT_W'(1);
					sum_q <= sum_ext[SUM_W] ? SUM_LIMIT : sum_ext[SUM_W-1:0];
				end
			end
			if (cmd.finish && fe_q) begin
				if (cs_q) begin
					smin_q <= run_min_q;
					smax_q <= run_max_q;
					savg_q <= quo_q;
				end
				run_min_q <= LUMA_FULL;
				run_max_q <= '0;
				sum_q     <= '0;
				cnt_q     <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign stat      = '{need_div: need_div_d, out_free: (!out_valid_q || out_ready)};

endmodule

`default_nettype wire

// ===== sv/rgb565_luma_stretch_unit.sv =====
// top level of the rgb565 luma stretch block
// depends on rls_pkg, rls_ctrl and rls_datapath
`default_nettype none

// Converts one RGB565 pixel per item into an 8-bit gray value, floor((30r+59g+11b)/100)
// on the channels widened to 8 bits, and returns exactly one result item per input item.
// Frames taken while collect_stats is set gather min, max and average luma, which are
// stored when the item with frame_end arrives; in other frames stretch_enable rescales
// luma from the stored [min, max] onto 0..255 when that range exceeds 8, and
// invert_enable outputs 255 minus the value. Items are processed one at a time: an
// accepted item is converted, scaled and accumulated and the divider is set up; an item
// that needs a division (a stretched pixel, or the last pixel of a statistics frame
// whose average does not saturate) then passes through a shared restoring divider that
// produces one quotient bit per cycle. The result is loaded into the output register
// when it is free; the next item is accepted no earlier than the cycle after the load.
// The result sits in an output register, so a new item can be accepted while the
// previous result still waits on out_ready. Configuration writes take effect at the
// next accepted item and are meant to be done while the block is idle.
module rgb565_luma_stretch_unit (
	input  wire                              clk,
	input  wire                              arst_n,
	// configuration write port
	input  wire                              cfg_we,
	input  wire  [rls_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  wire  [rls_pkg::CFG_DATA_W-1:0]   cfg_data,
	// input item channel
	input  wire                              in_valid,
	output logic                             in_ready,
	input  wire  [rls_pkg::PIX_W-1:0]        pixel,
	input  wire                              frame_end,
	// result item channel
	output logic                             out_valid,
	input  wire                              out_ready,
	output logic [rls_pkg::LUMA_W-1:0]       luma,
	output logic [rls_pkg::LUMA_W-1:0]       stat_min,
	output logic [rls_pkg::LUMA_W-1:0]       stat_max,
	output logic [rls_pkg::LUMA_W-1:0]       stat_avg,
	output logic                             last
);
	import rls_pkg::*;

	rls_cmd_t  cmd;
	rls_stat_t stat;

	// sequencer: accept, convert, scale, accumulate, divider setup, divide, deliver
	rls_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// arithmetic, statistics state, config registers and the output register
	rls_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.pixel     (pixel),
		.frame_end (frame_end),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.luma      (luma),
		.stat_min  (stat_min),
		.stat_max  (stat_max),
		.stat_avg  (stat_avg),
		.last      (last)
	);

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// self-checking testbench for rgb565_luma_stretch_unit: directed and random pixel frames
// predicts every result item in-line and compares it field by field
// depends on rls_pkg and the rgb565_luma_stretch_unit rtl
`default_nettype none

module testbench;
	import rls_pkg::*;

	localparam int unsigned CYCLE_LIMIT     = 300000;
	localparam int unsigned ITEM_TARGET     = 550;
	localparam int unsigned CALM_ITEMS      = 80;	// final stretch without idling
	localparam int unsigned SETTLE_CYCLES   = 30;	// settling wait for stray results after the drain
	localparam int unsigned PIXEL_CAP       = 1048576;
	localparam int unsigned SUM_CAP         = 32'h0FFFFFFF;
	localparam int unsigned STRETCH_FLOOR   = 8;

	// one predicted result item
	typedef struct {
		logic [LUMA_W-1:0] luma;
		logic [LUMA_W-1:0] smin;
		logic [LUMA_W-1:0] smax;
		logic [LUMA_W-1:0] savg;
		logic              last;
	} luma_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic [PIX_W-1:0]      pixel;
	logic                  frame_end;
	logic                  out_valid;
	logic                  out_ready;
	logic [LUMA_W-1:0]     luma;
	logic [LUMA_W-1:0]     stat_min;
	logic [LUMA_W-1:0]     stat_max;
	logic [LUMA_W-1:0]     stat_avg;
	logic                  last;

	rgb565_luma_stretch_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.pixel     (pixel),
		.frame_end (frame_end),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.luma      (luma),
		.stat_min  (stat_min),
		.stat_max  (stat_max),
		.stat_avg  (stat_avg),
		.last      (last)
	);

	// shadow of the block: register copies, stored statistics, running accumulators
	logic              cfg_collect = 1'b0;
	logic              cfg_stretch = 1'b0;
	logic              cfg_invert  = 1'b0;
	logic [7:0]        st_min      = 8'd0;
	logic [7:0]        st_max      = 8'd0;
	logic [7:0]        st_avg      = 8'd0;
	logic [7:0]        run_min     = 8'd255;
	logic [7:0]        run_max     = 8'd0;
	logic [SUM_W-1:0]  run_sum     = '0;
	logic [CNT_W-1:0]  run_count   = '0;

	luma_result_t luma_expect_q[$];
	int unsigned  mismatches    = 0;
	int unsigned  items_sent    = 0;
	int unsigned  cycle_count   = 0;
	int unsigned  rx_hold_cycles = 0;	// long receiver hold-off, picked up by the receiver
	bit           idle_on       = 1'b1;	// random idling on both channels

	// clock and cycle limit
	initial clk = 1'b0;
	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("rgb565_luma_stretch_unit verification failed");
			$finish;
		end
	end

	// every input at a known value from time zero
	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_idx   = '0;
		cfg_data  = '0;
		in_valid  = 1'b0;
		pixel     = '0;
		frame_end = 1'b0;
		out_ready = 1'b0;
	end

	// gray value of one pixel, then statistics or stretch, then inversion;
	// updates the shadow state exactly as the block does on acceptance
	function automatic luma_result_t luma_predict(input logic [PIX_W-1:0] pix,
			input logic fe);
		int unsigned  r;
		int unsigned  g;
		int unsigned  b;
		int unsigned  y;
		int unsigned  span;
		int unsigned  s;
		int unsigned  sum_next;
		int unsigned  avg;
		luma_result_t res;
		r = 32'({pix[15:11], 3'b000});
		g = 32'({pix[10:5], 2'b00});
		b = 32'({pix[4:0], 3'b000});
		y = (r * 30 + g * 59 + b * 11) / 100;
		if (cfg_collect) begin
			if (y < run_min) run_min = y[7:0];
			if (y > run_max) run_max = y[7:0];
			// past the pixel cap the sum and count freeze; the sum saturates
			if (run_count < PIXEL_CAP) begin
				run_count = run_count + CNT_W'(1);
				sum_next  = run_sum + y;
				run_sum   = (sum_next > SUM_CAP) ? SUM_CAP[SUM_W-1:0] : sum_next[SUM_W-1:0];
			end
		end else if (cfg_stretch && st_max > st_min) begin
			span = 32'(st_max) - 32'(st_min);
			// a range of 8 or less is left unstretched
			if (span > STRETCH_FLOOR) begin
				s = (y > st_min) ? y - st_min : 0;
				if (s > span) s = span;
				y = s * 255 / span;
			end
		end
		if (cfg_invert) y = 255 - y;
		if (fe) begin
			if (cfg_collect) begin
				avg = (run_count != 0) ? 32'(run_sum) / 32'(run_count) : 0;
				if (avg > 255) avg = 255;
				st_min = run_min;
				st_max = run_max;
				st_avg = avg[7:0];
			end
			// any frame end clears the accumulators, whatever the pass kind
			run_min   = 8'd255;
			run_max   = 8'd0;
			run_sum   = '0;
			run_count = '0;
		end
		res.luma = y[7:0];
		res.smin = st_min;
		res.smax = st_max;
		res.savg = st_avg;
		res.last = fe;
		return res;
	endfunction

	// pixel mix: full random, low-intensity blue for tight ranges, sparse bits
	function automatic logic [PIX_W-1:0] pick_pixel();
		logic [PIX_W-1:0] p;
		case ($urandom_range(0, 3))
			0: begin
				p = PIX_W'($urandom_range(0, 31));
			end
			1: begin
				p = PIX_W'($urandom_range(0, 65535));
				p = p & 16'h18E3;
			end
			default: begin
				p = PIX_W'($urandom_range(0, 65535));
			end
		endcase
		return p;
	endfunction

	// all three registers, one write per cycle; called right after a rising edge
	task automatic set_config(input logic collect, input logic stretch, input logic invert);
		cfg_we   <= 1'b1;
		cfg_idx  <= CFG_COLLECT_STATS;
		cfg_data <= collect;
		@(posedge clk);
		cfg_idx  <= CFG_STRETCH_ENABLE;
		cfg_data <= stretch;
		@(posedge clk);
		cfg_idx  <= CFG_INVERT_ENABLE;
		cfg_data <= invert;
		@(posedge clk);
		cfg_we   <= 1'b0;
		cfg_collect = collect;
		cfg_stretch = stretch;
		cfg_invert  = invert;
	endtask

	// offer one item, optionally after a random gap, and hold it until accepted;
	// the expectation is queued at the accepting edge
	task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic fe);
		int unsigned gap;
		gap = 0;
		if (idle_on && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 6);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		pixel     <= pix;
		frame_end <= fe;
		do @(posedge clk); while (!in_ready);
		luma_expect_q.push_back(luma_predict(pix, fe));
		items_sent++;
	endtask

	task automatic stop_sending();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	// sender pause: nothing goes in until every outstanding result is back
	task automatic wait_drained();
		stop_sending();
		while (luma_expect_q.size() != 0) @(posedge clk);
	endtask

	task automatic send_frame(input int unsigned len);
		for (int unsigned i = 0; i < len; i++)
			send_pixel(pick_pixel(), i == len - 1);
	endtask

	// extremes of every field with the registers at rest, then inversion and
	// stretch enabled over the empty stored range left by reset
	task automatic test_pixel_extremes();
		set_config(1'b0, 1'b0, 1'b0);
		send_pixel(16'h0000, 1'b0);
		send_pixel(16'hFFFF, 1'b0);
		send_pixel(16'hF800, 1'b0);
		send_pixel(16'h07E0, 1'b0);
		send_pixel(16'h001F, 1'b0);
		send_pixel(16'h0000, 1'b1);
		wait_drained();
		set_config(1'b0, 1'b1, 1'b1);
		send_pixel(16'hFFFF, 1'b0);
		send_pixel(16'h0000, 1'b1);
		wait_drained();
	endtask

	// statistics frame, then stretched frames with clamping below min and above max
	task automatic test_stats_and_stretch();
		set_config(1'b1, 1'b1, 1'b1);
		send_pixel(16'h2104, 1'b0);
		send_pixel(16'hF81F, 1'b0);
		send_pixel(16'h07E0, 1'b0);
		send_pixel(16'h0841, 1'b1);
		wait_drained();
		set_config(1'b0, 1'b1, 1'b0);
		send_pixel(16'h0000, 1'b0);
		send_pixel(16'hFFFF, 1'b0);
		send_pixel(16'h8410, 1'b0);
		send_pixel(16'h4208, 1'b1);
		wait_drained();
		set_config(1'b0, 1'b1, 1'b1);
		send_pixel(16'hFFFF, 1'b0);
		send_pixel(16'h0000, 1'b1);
		wait_drained();
	endtask

	// stored range of exactly 8 (no stretch) and of 9 (stretch); blue 10 -> 8, blue 11 -> 9
	task automatic test_range_threshold();
		set_config(1'b1, 1'b0, 1'b0);
		send_pixel(16'h0000, 1'b0);
		send_pixel(16'h000A, 1'b1);
		wait_drained();
		set_config(1'b0, 1'b1, 1'b0);
		send_pixel(16'h0005, 1'b1);
		wait_drained();
		set_config(1'b1, 1'b0, 1'b0);
		send_pixel(16'h0000, 1'b0);
		send_pixel(16'h000B, 1'b1);
		wait_drained();
		set_config(1'b0, 1'b1, 1'b0);
		send_pixel(16'h0005, 1'b1);
		wait_drained();
	endtask

	// statistics switched off before the frame end: no store, accumulators still clear
	task automatic test_midframe_switch();
		set_config(1'b1, 1'b0, 1'b0);
		send_pixel(16'hFFFF, 1'b0);
		wait_drained();
		set_config(1'b0, 1'b0, 1'b0);
		send_pixel(16'h0000, 1'b1);
		wait_drained();
		set_config(1'b0, 1'b1, 1'b0);
		send_pixel(16'h8410, 1'b1);
		wait_drained();
	endtask

	// receiver holds off for a long stretch while the sender keeps offering
	// back-to-back items, so the block fills and drops in_ready
	task automatic test_backpressure();
		idle_on = 1'b0;
		set_config(1'b0, 1'b1, 1'b0);
		rx_hold_cycles = 60;
		for (int i = 0; i < 24; i++)
			send_pixel(pick_pixel(), ($urandom_range(0, 5) == 0));
		wait_drained();
		idle_on = 1'b1;
	endtask

	// mostly a statistics frame followed by normal frames with random content,
	// sometimes random registers and stray frame ends
	task automatic test_random_frames();
		int unsigned n_frames;
		int unsigned n_items;
		while (items_sent < ITEM_TARGET) begin
			if (items_sent + CALM_ITEMS >= ITEM_TARGET) idle_on = 1'b0;
			if ($urandom_range(0, 3) != 0) begin
				set_config(1'b1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				send_frame($urandom_range(1, 16));
				wait_drained();
				set_config(1'b0, ($urandom_range(0, 4) != 0), 1'($urandom_range(0, 1)));
				n_frames = $urandom_range(1, 3);
				repeat (n_frames) send_frame($urandom_range(1, 16));
				wait_drained();
			end else begin
				set_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)));
				n_items = $urandom_range(1, 10);
				repeat (n_items) send_pixel(pick_pixel(), ($urandom_range(0, 3) == 0));
				wait_drained();
			end
		end
	endtask

	// receiver: random stall bursts, a long hold-off on request, and ready runs
	initial begin : receiver
		int unsigned n;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (rx_hold_cycles != 0) begin
				n = rx_hold_cycles;
				rx_hold_cycles = 0;
				out_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	task automatic compare_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// result checker: each accepted result against the oldest expectation
	always @(posedge clk) begin : result_check
		luma_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (luma_expect_q.size() == 0) begin
				$error("result item with no expectation pending");
				mismatches++;
			end else begin
				want = luma_expect_q.pop_front();
				compare_field("luma", want.luma, luma);
				compare_field("stat_min", want.smin, stat_min);
				compare_field("stat_max", want.smax, stat_max);
				compare_field("stat_avg", want.savg, stat_avg);
				compare_field("last", {7'd0, want.last}, {7'd0, last});
			end
		end
	end

	// sequence: reset, directed tests, pressure, random frames, settle, verdict
	initial begin : sequencer
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_pixel_extremes();
		test_stats_and_stretch();
		test_range_threshold();
		test_midframe_switch();
		test_backpressure();
		test_random_frames();
		wait_drained();
		// catch any stray result after the last expected one
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && luma_expect_q.size() == 0) begin
			$display("rgb565_luma_stretch_unit verification clean");
		end else begin
			$display("rgb565_luma_stretch_unit verification failed");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== filelist.f =====
sv/rls_pkg.sv
sv/rls_ctrl.sv
sv/rls_datapath.sv
sv/rgb565_luma_stretch_unit.sv
dv/testbench.sv
